>>> rtl/homography_point_transform_core_defines.svh
// ---------------------------------------------------------------------------
// Homography point transform assertion macros
// Shared assertion helpers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef HOMOGRAPHY_POINT_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGRAPHY_POINT_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active.
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is active.
`define HPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/hpt_pkg.sv
// ---------------------------------------------------------------------------
// Homography point transform package
// Fixed-point formats, register indexes and the per-point flag bundle.
// ---------------------------------------------------------------------------
package hpt_pkg;

    // Fixed-point formats.
    localparam int COORD_FRAC      = 4;
    localparam int COEF_FRAC       = 32;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_COEF_WIDTH  = 48;

    // Coefficient value 1.0 before truncation to the register width.
    localparam logic [63:0] COEF_ONE = 64'(1) << COEF_FRAC;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX = 3'd0,
        CFG_COEF_XY = 3'd1,
        CFG_COEF_XT = 3'd2,
        CFG_COEF_YX = 3'd3,
        CFG_COEF_YY = 3'd4,
        CFG_COEF_YT = 3'd5,
        CFG_COEF_WX = 3'd6,
        CFG_COEF_WY = 3'd7
    } t_cfg_idx;

    // Status that travels with each point through the divider.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero;
        logic ovf_x;
        logic ovf_y;
    } t_hpt_flags;

endpackage

>>> rtl/hpt_mac.sv
// ---------------------------------------------------------------------------
// Homography linear form
// Three-stage pipeline computing c1*x + c2*y + addend exactly.
// ---------------------------------------------------------------------------
module hpt_mac #(
    parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = hpt_pkg::DEF_COEF_WIDTH
) (
    input  logic                                   i_clk,
    input  logic [2:0]                             i_en,
    input  logic signed [COORD_WIDTH-1:0]          i_x,
    input  logic signed [COORD_WIDTH-1:0]          i_y,
    input  logic signed [COEF_WIDTH-1:0]           i_coef_x,
    input  logic signed [COEF_WIDTH-1:0]           i_coef_y,
    input  logic signed [COEF_WIDTH+COORD_WIDTH:0] i_addend,
    output logic signed [COEF_WIDTH+COORD_WIDTH:0] o_sum
);

    localparam int LO_W    = COEF_WIDTH / 2;
    localparam int HI_W    = COEF_WIDTH - LO_W;
    localparam int PP_HI_W = HI_W + COORD_WIDTH;
    localparam int PP_LO_W = LO_W + 1 + COORD_WIDTH;
    localparam int PROD_W  = COEF_WIDTH + COORD_WIDTH;
    localparam int SUM_W   = PROD_W + 1;

    // Coefficient halves: signed upper part, unsigned lower part.
    logic signed [HI_W-1:0] w_cx_hi;
    logic signed [HI_W-1:0] w_cy_hi;
    logic signed [LO_W:0]   w_cx_lo;
    logic signed [LO_W:0]   w_cy_lo;

    assign w_cx_hi = i_coef_x[COEF_WIDTH-1:LO_W];
    assign w_cy_hi = i_coef_y[COEF_WIDTH-1:LO_W];
    assign w_cx_lo = {1'b0, i_coef_x[LO_W-1:0]};
    assign w_cy_lo = {1'b0, i_coef_y[LO_W-1:0]};

    // Stage 0: four partial products, each no wider than 25 by 16 bits at the default widths.
    logic signed [PP_HI_W-1:0] r_ppx_hi;
    logic signed [PP_HI_W-1:0] r_ppy_hi;
    logic signed [PP_LO_W-1:0] r_ppx_lo;
    logic signed [PP_LO_W-1:0] r_ppy_lo;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ppx_hi <= PP_HI_W'(w_cx_hi) * PP_HI_W'(i_x);
            r_ppy_hi <= PP_HI_W'(w_cy_hi) * PP_HI_W'(i_y);
            r_ppx_lo <= PP_LO_W'(w_cx_lo) * PP_LO_W'(i_x);
            r_ppy_lo <= PP_LO_W'(w_cy_lo) * PP_LO_W'(i_y);
        end
    end

    // Stage 1: recombine the halves into full products.
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod_x <= (PROD_W'(r_ppx_hi) <<< LO_W) + PROD_W'(r_ppx_lo);
            r_prod_y <= (PROD_W'(r_ppy_hi) <<< LO_W) + PROD_W'(r_ppy_lo);
        end
    end

    // Stage 2: add both products and the constant term.
    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sum <= SUM_W'(r_prod_x) + SUM_W'(r_prod_y) + i_addend;
        end
    end

    assign o_sum = r_sum;

endmodule

>>> rtl/hpt_prep.sv
// ---------------------------------------------------------------------------
// Homography divide preparation
// Takes magnitudes and signs of u, v, w and flags zero and overflow.
// ---------------------------------------------------------------------------
module hpt_prep #(
    parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = hpt_pkg::DEF_COEF_WIDTH
) (
    input  logic                                          i_clk,
    input  logic [1:0]                                    i_en,
    input  logic signed [COEF_WIDTH+COORD_WIDTH:0]        i_u,
    input  logic signed [COEF_WIDTH+COORD_WIDTH:0]        i_v,
    input  logic signed [COEF_WIDTH+COORD_WIDTH:0]        i_w,
    output logic [COEF_WIDTH+COORD_WIDTH+hpt_pkg::COORD_FRAC:0] o_num_x,
    output logic [COEF_WIDTH+COORD_WIDTH+hpt_pkg::COORD_FRAC:0] o_num_y,
    output logic [COEF_WIDTH+COORD_WIDTH:0]               o_den,
    output hpt_pkg::t_hpt_flags                           o_flags
);

    import hpt_pkg::*;

    localparam int SUM_W = COEF_WIDTH + COORD_WIDTH + 1;
    localparam int NUM_W = SUM_W + COORD_FRAC;
    localparam int CMP_W = SUM_W + COORD_WIDTH + 1;

    // Stage 3: magnitudes, result signs and the zero divisor check.
    logic [SUM_W-1:0] w_abs_u;
    logic [SUM_W-1:0] w_abs_v;
    logic [SUM_W-1:0] w_abs_w;

    assign w_abs_u = i_u[SUM_W-1] ? -i_u : i_u;
    assign w_abs_v = i_v[SUM_W-1] ? -i_v : i_v;
    assign w_abs_w = i_w[SUM_W-1] ? -i_w : i_w;

    logic [NUM_W-1:0] r_s3_num_x;
    logic [NUM_W-1:0] r_s3_num_y;
    logic [SUM_W-1:0] r_s3_den;
    t_hpt_flags       r_s3_flags;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s3_num_x       <= {w_abs_u, {COORD_FRAC{1'b0}}};
            r_s3_num_y       <= {w_abs_v, {COORD_FRAC{1'b0}}};
            r_s3_den         <= w_abs_w;
            r_s3_flags.neg_x <= i_u[SUM_W-1] ^ i_w[SUM_W-1];
            r_s3_flags.neg_y <= i_v[SUM_W-1] ^ i_w[SUM_W-1];
            r_s3_flags.zero  <= (i_w == '0);
            r_s3_flags.ovf_x <= 1'b0;
            r_s3_flags.ovf_y <= 1'b0;
        end
    end

    // Stage 4: the quotient needs more bits than the divider makes when
    // the numerator reaches the divisor shifted past the top quotient bit.
    logic [CMP_W-1:0] w_den_top;
    t_hpt_flags       w_s4_flags;

    assign w_den_top = CMP_W'(r_s3_den) << (COORD_WIDTH + 1);

    always_comb begin
        w_s4_flags       = r_s3_flags;
        w_s4_flags.ovf_x = CMP_W'(r_s3_num_x) >= w_den_top;
        w_s4_flags.ovf_y = CMP_W'(r_s3_num_y) >= w_den_top;
    end

    logic [NUM_W-1:0] r_s4_num_x;
    logic [NUM_W-1:0] r_s4_num_y;
    logic [SUM_W-1:0] r_s4_den;
    t_hpt_flags       r_s4_flags;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s4_num_x <= r_s3_num_x;
            r_s4_num_y <= r_s3_num_y;
            r_s4_den   <= r_s3_den;
            r_s4_flags <= w_s4_flags;
        end
    end

    assign o_num_x = r_s4_num_x;
    assign o_num_y = r_s4_num_y;
    assign o_den   = r_s4_den;
    assign o_flags = r_s4_flags;

endmodule

>>> rtl/hpt_div.sv
// ---------------------------------------------------------------------------
// Homography pipelined divider
// Restoring division of both numerators by the shared divisor, one
// quotient bit per stage, followed by a round-to-nearest decision stage.
// ---------------------------------------------------------------------------
module hpt_div #(
    parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = hpt_pkg::DEF_COEF_WIDTH
) (
    input  logic                                          i_clk,
    input  logic [COORD_WIDTH+1:0]                        i_en,
    input  logic [COEF_WIDTH+COORD_WIDTH+hpt_pkg::COORD_FRAC:0] i_num_x,
    input  logic [COEF_WIDTH+COORD_WIDTH+hpt_pkg::COORD_FRAC:0] i_num_y,
    input  logic [COEF_WIDTH+COORD_WIDTH:0]               i_den,
    input  hpt_pkg::t_hpt_flags                           i_flags,
    output logic [COORD_WIDTH:0]                          o_q_x,
    output logic [COORD_WIDTH:0]                          o_q_y,
    output logic                                          o_round_x,
    output logic                                          o_round_y,
    output hpt_pkg::t_hpt_flags                           o_flags
);

    import hpt_pkg::*;

    localparam int SUM_W = COEF_WIDTH + COORD_WIDTH + 1;
    localparam int RW    = SUM_W + COORD_WIDTH + 1;
    localparam int NSTEP = COORD_WIDTH + 1;
    localparam int QW    = COORD_WIDTH + 1;

    // Step registers; step j decides quotient bit COORD_WIDTH - j.
    logic [RW-1:0]    r_rem_x [NSTEP];
    logic [RW-1:0]    r_rem_y [NSTEP];
    logic [SUM_W-1:0] r_den   [NSTEP];
    logic [QW-1:0]    r_q_x   [NSTEP];
    logic [QW-1:0]    r_q_y   [NSTEP];
    t_hpt_flags       r_flags [NSTEP];

    // Inputs of each step and its trial subtraction.
    logic [RW-1:0]    w_rem_in_x [NSTEP];
    logic [RW-1:0]    w_rem_in_y [NSTEP];
    logic [SUM_W-1:0] w_den_in   [NSTEP];
    logic [QW-1:0]    w_q_in_x   [NSTEP];
    logic [QW-1:0]    w_q_in_y   [NSTEP];
    t_hpt_flags       w_flags_in [NSTEP];
    logic [RW-1:0]    w_trial    [NSTEP];
    logic [RW-1:0]    w_diff_x   [NSTEP];
    logic [RW-1:0]    w_diff_y   [NSTEP];
    logic             w_brw_x    [NSTEP];
    logic             w_brw_y    [NSTEP];
    logic [QW-1:0]    w_bit      [NSTEP];

    always_comb begin
        w_rem_in_x[0] = RW'(i_num_x);
        w_rem_in_y[0] = RW'(i_num_y);
        w_den_in[0]   = i_den;
        w_q_in_x[0]   = '0;
        w_q_in_y[0]   = '0;
        w_flags_in[0] = i_flags;
        for (int j = 1; j < NSTEP; j++) begin
            w_rem_in_x[j] = r_rem_x[j-1];
            w_rem_in_y[j] = r_rem_y[j-1];
            w_den_in[j]   = r_den[j-1];
            w_q_in_x[j]   = r_q_x[j-1];
            w_q_in_y[j]   = r_q_y[j-1];
            w_flags_in[j] = r_flags[j-1];
        end
        for (int j = 0; j < NSTEP; j++) begin
            w_trial[j] = RW'(w_den_in[j]) << (COORD_WIDTH - j);
            w_bit[j]   = QW'(1) << (COORD_WIDTH - j);
            {w_brw_x[j], w_diff_x[j]} = {1'b0, w_rem_in_x[j]} - {1'b0, w_trial[j]};
            {w_brw_y[j], w_diff_y[j]} = {1'b0, w_rem_in_y[j]} - {1'b0, w_trial[j]};
        end
    end

    // Keep the difference and set the quotient bit when no borrow occurs.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NSTEP; j++) begin
            if (i_en[j]) begin
                r_rem_x[j] <= w_brw_x[j] ? w_rem_in_x[j] : w_diff_x[j];
                r_rem_y[j] <= w_brw_y[j] ? w_rem_in_y[j] : w_diff_y[j];
                r_q_x[j]   <= w_q_in_x[j] | (w_brw_x[j] ? '0 : w_bit[j]);
                r_q_y[j]   <= w_q_in_y[j] | (w_brw_y[j] ? '0 : w_bit[j]);
                r_den[j]   <= w_den_in[j];
                r_flags[j] <= w_flags_in[j];
            end
        end
    end

    // Round stage: round up when twice the remainder reaches the divisor.
    logic [SUM_W-1:0] w_rem_x;
    logic [SUM_W-1:0] w_rem_y;

    assign w_rem_x = r_rem_x[NSTEP-1][SUM_W-1:0];
    assign w_rem_y = r_rem_y[NSTEP-1][SUM_W-1:0];

    logic [QW-1:0] r_qo_x;
    logic [QW-1:0] r_qo_y;
    logic          r_rnd_x;
    logic          r_rnd_y;
    t_hpt_flags    r_flags_o;

    always_ff @(posedge i_clk) begin
        if (i_en[NSTEP]) begin
            r_qo_x    <= r_q_x[NSTEP-1];
            r_qo_y    <= r_q_y[NSTEP-1];
            r_rnd_x   <= {w_rem_x, 1'b0} >= {1'b0, r_den[NSTEP-1]};
            r_rnd_y   <= {w_rem_y, 1'b0} >= {1'b0, r_den[NSTEP-1]};
            r_flags_o <= r_flags[NSTEP-1];
        end
    end

    assign o_q_x     = r_qo_x;
    assign o_q_y     = r_qo_y;
    assign o_round_x = r_rnd_x;
    assign o_round_y = r_rnd_y;
    assign o_flags   = r_flags_o;

endmodule

>>> rtl/homography_point_transform_core.sv
// ---------------------------------------------------------------------------
// Homography point transform core
// Maps Q12.4 points through a planar homography held in eight registers.
// ---------------------------------------------------------------------------
// Usage:
//   A request on the input channel (i_valid, o_stall) carries one point
//   (i_x_in, i_y_in). The result request on the output channel (o_valid,
//   i_stall) carries the mapped point, a saturation flag and a zero divisor
//   flag. Coefficients are written through i_cfg_we / i_cfg_addr /
//   i_cfg_wdata while no point is in flight.
//   The pipeline holds three multiply and sum stages, two divide
//   preparation stages, one restoring divider stage per quotient bit
//   (COORD_WIDTH + 1), one rounding stage and the output register.
//   Throughput is one point per cycle while o_stall is low.
//   Reset clears every valid bit and loads the identity homography.
//   When the receiver stalls, the output register holds its result and
//   empty stages behind it keep filling; o_stall rises only once every
//   stage holds a point, so nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "homography_point_transform_core_defines.svh"

module homography_point_transform_core #(
    parameter int COORD_WIDTH = hpt_pkg::DEF_COORD_WIDTH,
    parameter int COEF_WIDTH  = hpt_pkg::DEF_COEF_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input point channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_x_in,
    input  logic signed [COORD_WIDTH-1:0]     i_y_in,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [COORD_WIDTH-1:0]     o_x_out,
    output logic signed [COORD_WIDTH-1:0]     o_y_out,
    output logic                              o_saturated,
    output logic                              o_zero_divisor,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [COEF_WIDTH-1:0]             i_cfg_wdata
);

    import hpt_pkg::*;

    localparam int SUM_W = COEF_WIDTH + COORD_WIDTH + 1;
    localparam int NUM_W = SUM_W + COORD_FRAC;
    localparam int QW    = COORD_WIDTH + 1;
    localparam int NSTG  = COORD_WIDTH + 8;

    localparam logic [QW:0] LIM_NEG = (QW+1)'(1) << (COORD_WIDTH - 1);
    localparam logic [QW:0] LIM_POS = LIM_NEG - 1'b1;

    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = LIM_POS[COORD_WIDTH-1:0];
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = LIM_NEG[COORD_WIDTH-1:0];

    localparam logic signed [SUM_W-1:0] W_ONE = SUM_W'(1) << (COEF_FRAC + COORD_FRAC);

    // Coefficient registers.
    logic signed [COEF_WIDTH-1:0] r_coef_xx;
    logic signed [COEF_WIDTH-1:0] r_coef_xy;
    logic signed [COEF_WIDTH-1:0] r_coef_xt;
    logic signed [COEF_WIDTH-1:0] r_coef_yx;
    logic signed [COEF_WIDTH-1:0] r_coef_yy;
    logic signed [COEF_WIDTH-1:0] r_coef_yt;
    logic signed [COEF_WIDTH-1:0] r_coef_wx;
    logic signed [COEF_WIDTH-1:0] r_coef_wy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx <= COEF_WIDTH'(COEF_ONE);
            r_coef_xy <= '0;
            r_coef_xt <= '0;
            r_coef_yx <= '0;
            r_coef_yy <= COEF_WIDTH'(COEF_ONE);
            r_coef_yt <= '0;
            r_coef_wx <= '0;
            r_coef_wy <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_COEF_XX: r_coef_xx <= i_cfg_wdata;
                CFG_COEF_XY: r_coef_xy <= i_cfg_wdata;
                CFG_COEF_XT: r_coef_xt <= i_cfg_wdata;
                CFG_COEF_YX: r_coef_yx <= i_cfg_wdata;
                CFG_COEF_YY: r_coef_yy <= i_cfg_wdata;
                CFG_COEF_YT: r_coef_yt <= i_cfg_wdata;
                CFG_COEF_WX: r_coef_wx <= i_cfg_wdata;
                CFG_COEF_WY: r_coef_wy <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline occupancy: a stage may load when it or any stage after it
    // is empty, or when the receiver takes the result.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_rdy;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_rdy[k] = !i_stall || ((~r_vld >> k) != '0);
        end
        n_vld = (r_vld & ~w_rdy) | ({r_vld[NSTG-2:0], i_valid} & w_rdy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // Linear forms u, v and w.
    logic signed [SUM_W-1:0] w_add_u;
    logic signed [SUM_W-1:0] w_add_v;
    logic signed [SUM_W-1:0] w_u;
    logic signed [SUM_W-1:0] w_v;
    logic signed [SUM_W-1:0] w_w;

    assign w_add_u = SUM_W'(r_coef_xt) <<< COORD_FRAC;
    assign w_add_v = SUM_W'(r_coef_yt) <<< COORD_FRAC;

    hpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac_u (
        .i_clk    (i_clk),
        .i_en     (w_rdy[2:0]),
        .i_x      (i_x_in),
        .i_y      (i_y_in),
        .i_coef_x (r_coef_xx),
        .i_coef_y (r_coef_xy),
        .i_addend (w_add_u),
        .o_sum    (w_u)
    );

    hpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac_v (
        .i_clk    (i_clk),
        .i_en     (w_rdy[2:0]),
        .i_x      (i_x_in),
        .i_y      (i_y_in),
        .i_coef_x (r_coef_yx),
        .i_coef_y (r_coef_yy),
        .i_addend (w_add_v),
        .o_sum    (w_v)
    );

    hpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac_w (
        .i_clk    (i_clk),
        .i_en     (w_rdy[2:0]),
        .i_x      (i_x_in),
        .i_y      (i_y_in),
        .i_coef_x (r_coef_wx),
        .i_coef_y (r_coef_wy),
        .i_addend (W_ONE),
        .o_sum    (w_w)
    );

    // Magnitudes, signs, zero and overflow checks.
    logic [NUM_W-1:0] w_num_x;
    logic [NUM_W-1:0] w_num_y;
    logic [SUM_W-1:0] w_den;
    t_hpt_flags       w_prep_flags;

    hpt_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_en    (w_rdy[4:3]),
        .i_u     (w_u),
        .i_v     (w_v),
        .i_w     (w_w),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den),
        .o_flags (w_prep_flags)
    );

    // Divider and rounding decision.
    logic [QW-1:0] w_q_x;
    logic [QW-1:0] w_q_y;
    logic          w_rnd_x;
    logic          w_rnd_y;
    t_hpt_flags    w_flags;

    hpt_div #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_en      (w_rdy[NSTG-2:5]),
        .i_num_x   (w_num_x),
        .i_num_y   (w_num_y),
        .i_den     (w_den),
        .i_flags   (w_prep_flags),
        .o_q_x     (w_q_x),
        .o_q_y     (w_q_y),
        .o_round_x (w_rnd_x),
        .o_round_y (w_rnd_y),
        .o_flags   (w_flags)
    );

    // Output stage: apply rounding, clamp to range, restore the sign, clear on a zero divisor.
    logic [QW:0]              w_qr_x;
    logic [QW:0]              w_qr_y;
    logic [QW:0]              w_lim_x;
    logic [QW:0]              w_lim_y;
    logic [QW:0]              w_mag_x;
    logic [QW:0]              w_mag_y;
    logic                     w_sat_x;
    logic                     w_sat_y;
    logic [COORD_WIDTH-1:0]   w_res_x;
    logic [COORD_WIDTH-1:0]   w_res_y;

    always_comb begin
        w_qr_x  = (QW+1)'(w_q_x) + (QW+1)'(w_rnd_x);
        w_qr_y  = (QW+1)'(w_q_y) + (QW+1)'(w_rnd_y);
        w_lim_x = w_flags.neg_x ? LIM_NEG : LIM_POS;
        w_lim_y = w_flags.neg_y ? LIM_NEG : LIM_POS;
        w_sat_x = w_flags.ovf_x || (w_qr_x > w_lim_x);
        w_sat_y = w_flags.ovf_y || (w_qr_y > w_lim_y);
        w_mag_x = w_sat_x ? w_lim_x : w_qr_x;
        w_mag_y = w_sat_y ? w_lim_y : w_qr_y;
        w_res_x = w_flags.neg_x ? COORD_WIDTH'(-w_mag_x) : COORD_WIDTH'(w_mag_x);
        w_res_y = w_flags.neg_y ? COORD_WIDTH'(-w_mag_y) : COORD_WIDTH'(w_mag_y);
    end

    logic signed [COORD_WIDTH-1:0] r_x_out;
    logic signed [COORD_WIDTH-1:0] r_y_out;
    logic                          r_sat;
    logic                          r_zero;

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1]) begin
            r_x_out <= w_flags.zero ? '0 : w_res_x;
            r_y_out <= w_flags.zero ? '0 : w_res_y;
            r_sat   <= !w_flags.zero && (w_sat_x || w_sat_y);
            r_zero  <= w_flags.zero;
        end
    end

    assign o_x_out        = r_x_out;
    assign o_y_out        = r_y_out;
    assign o_saturated    = r_sat;
    assign o_zero_divisor = r_zero;

    // Checks on the pipeline control and the result encoding.
    `HPT_ASSERT_IMP(a_zero_div_clean, i_clk, i_rst_n, o_valid && o_zero_divisor, o_x_out == '0 && o_y_out == '0 && !o_saturated, "zero divisor result is not cleared")
    `HPT_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_stall, (&r_vld) && i_stall, "input stalled while the pipeline has room")
    `HPT_ASSERT_IMP(a_sat_at_bound, i_clk, i_rst_n, o_valid && o_saturated, o_x_out == SAT_MAX || o_x_out == SAT_MIN || o_y_out == SAT_MAX || o_y_out == SAT_MIN, "saturated result is not at a bound")
    `HPT_ASSERT_IMP(a_out_from_round, i_clk, i_rst_n, $rose(o_valid), $past(r_vld[NSTG-2]), "result appeared without a point behind it")
    `HPT_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, o_valid && !i_stall && !r_vld[NSTG-2], !o_valid, "taken result was repeated")

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// Homography point transform core testbench
// Drives points through the core under several coefficient sets and checks
// each mapped point against a typed result or an exact wide-integer model.
// A short directed table covers identity, saturation, zero divisor, extreme
// coefficients and rounding ties. Random phases follow with fresh
// coefficients per phase and random idling on both channels.
// ---------------------------------------------------------------------------
module tb;
    import hpt_pkg::*;

    localparam int CW = DEF_COORD_WIDTH;
    localparam int KW = DEF_COEF_WIDTH;

    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_PAD       = CW + 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_IDLE        = 12;

    // Coefficient values used by the directed rows.
    localparam logic signed [KW-1:0] ONE_Q    = COEF_ONE[KW-1:0];
    localparam logic signed [KW-1:0] TWO_Q    = ONE_Q <<< 1;
    localparam logic signed [KW-1:0] HALF_Q   = ONE_Q >>> 1;
    localparam logic signed [KW-1:0] COEF_MAX = {1'b0, {(KW-1){1'b1}}};
    localparam logic signed [KW-1:0] COEF_MIN = {1'b1, {(KW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          sat;
        logic          zdiv;
    } t_mapped_pt;

    // A directed row is a plain point, a point with a typed result, or a write.
    typedef enum logic [1:0] {
        ROW_POINT,
        ROW_CHECKED,
        ROW_COEF
    } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic signed [KW-1:0]  coef;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        t_mapped_pt            want;
    } t_stim_row;

    typedef enum logic [1:0] {
        STYLE_AFFINE,
        STYLE_WILD,
        STYLE_SINGULAR
    } t_coef_style;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic signed [CW-1:0]  i_x_in       = '0;
    logic signed [CW-1:0]  i_y_in       = '0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic signed [CW-1:0]  o_x_out;
    logic signed [CW-1:0]  o_y_out;
    logic                  o_saturated;
    logic                  o_zero_divisor;
    logic                  i_cfg_we     = 1'b0;
    t_cfg_idx              i_cfg_addr   = CFG_COEF_XX;
    logic [KW-1:0]         i_cfg_wdata  = '0;

    // Typed result that travels with the current request, if any.
    logic                  req_checked  = 1'b0;
    t_mapped_pt            req_want     = '0;

    logic signed [KW-1:0]  coef_copy [8];
    t_mapped_pt            expected_pts [$];
    t_stim_row             dir_rows [$];
    int                    mismatch_cnt = 0;
    int                    idle_cycles  = 0;
    int                    hold_cnt     = 0;
    bit                    tx_burst     = 1'b0;
    bit                    rx_burst     = 1'b0;
    int                    hunt_shift   = 0;

    homography_point_transform_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_x_in         (i_x_in),
        .i_y_in         (i_y_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_saturated    (o_saturated),
        .o_zero_divisor (o_zero_divisor),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Rounded magnitude quotient with ties away from zero, clamped to the
    // coordinate range; the clamp is reported through the output flag.
    function automatic logic [CW-1:0] div_round_sat(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     output logic clamped);
        logic          neg;
        logic [127:0]  n;
        logic [127:0]  d;
        logic [127:0]  q;
        logic [127:0]  r;
        logic [127:0]  lim;
        neg = num[127] != den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = n / d;
        r = n % d;
        if (r >= d - r) begin
            q = q + 128'd1;
        end
        lim = (128'd1 << (CW - 1)) - (neg ? 128'd0 : 128'd1);
        clamped = 1'b0;
        if (q > lim) begin
            clamped = 1'b1;
            q = lim;
        end
        if (neg) begin
            q = -q;
        end
        return q[CW-1:0];
    endfunction

    // Exact transform of one point under the current coefficient copy.
    function automatic t_mapped_pt map_point(input logic signed [CW-1:0] px,
                                             input logic signed [CW-1:0] py);
        logic signed [127:0] c [8];
        logic signed [127:0] xs;
        logic signed [127:0] ys;
        logic signed [127:0] u;
        logic signed [127:0] v;
        logic signed [127:0] w;
        logic                clamp_x;
        logic                clamp_y;
        t_mapped_pt          res;
        for (int i = 0; i < 8; i++) begin
            c[i] = 128'(coef_copy[i]);
        end
        xs = 128'(px);
        ys = 128'(py);
        u = c[CFG_COEF_XX] * xs + c[CFG_COEF_XY] * ys + (c[CFG_COEF_XT] <<< COORD_FRAC);
        v = c[CFG_COEF_YX] * xs + c[CFG_COEF_YY] * ys + (c[CFG_COEF_YT] <<< COORD_FRAC);
        w = c[CFG_COEF_WX] * xs + c[CFG_COEF_WY] * ys
            + (128'sd1 <<< (COEF_FRAC + COORD_FRAC));
        if (w == 0) begin
            res.x    = '0;
            res.y    = '0;
            res.sat  = 1'b0;
            res.zdiv = 1'b1;
        end else begin
            res.x    = div_round_sat(u <<< COORD_FRAC, w, clamp_x);
            res.y    = div_round_sat(v <<< COORD_FRAC, w, clamp_y);
            res.sat  = clamp_x | clamp_y;
            res.zdiv = 1'b0;
        end
        return res;
    endfunction

    // Uniform value in [-2^bits, 2^bits).
    function automatic logic signed [KW-1:0] span_rand(input int bits);
        logic signed [63:0] r;
        r = {$urandom, $urandom};
        r = r >>> (63 - bits);
        return r[KW-1:0];
    endfunction

    // Coefficient for one register under the given phase style.
    function automatic logic signed [KW-1:0] pick_coef(input t_coef_style style,
                                                       input t_cfg_idx idx);
        logic signed [KW-1:0] val;
        if (style == STYLE_WILD) begin
            case ($urandom_range(0, 4))
                0: val = COEF_MAX;
                1: val = COEF_MIN;
                2: val = '0;
                3: val = span_rand(KW - 1);
                default: val = span_rand(34);
            endcase
        end else begin
            case (idx)
                CFG_COEF_XX, CFG_COEF_YY: begin
                    val = ONE_Q + span_rand(31);
                    if ($urandom_range(0, 7) == 0) begin
                        val = -val;
                    end
                end
                CFG_COEF_XY, CFG_COEF_YX: val = span_rand(30);
                CFG_COEF_XT, CFG_COEF_YT: val = span_rand(41);
                default: val = span_rand(20);
            endcase
            // A pure x perspective term that cancels w exactly at one x.
            if (style == STYLE_SINGULAR && idx == CFG_COEF_WX) begin
                val = -(ONE_Q >>> hunt_shift);
            end else if (style == STYLE_SINGULAR && idx == CFG_COEF_WY) begin
                val = '0;
            end
        end
        return val;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        logic signed [CW-1:0] val;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: val = {1'b1, {(CW-1){1'b0}}};
                    1: val = {1'b0, {(CW-1){1'b1}}};
                    2: val = '0;
                    3: val = CW'(1);
                    default: val = '1;
                endcase
            end
            1, 2: val = CW'(int'($urandom_range(0, 512)) - 256);
            default: val = CW'($urandom);
        endcase
        return val;
    endfunction

    function automatic t_stim_row row_pt(input int px, input int py);
        t_stim_row row;
        row.kind = ROW_POINT;
        row.idx  = CFG_COEF_XX;
        row.coef = '0;
        row.x    = CW'(px);
        row.y    = CW'(py);
        row.want = '0;
        return row;
    endfunction

    function automatic t_stim_row row_chk(input int px, input int py, input int ex,
                                          input int ey, input bit sat, input bit zdiv);
        t_stim_row row;
        row = row_pt(px, py);
        row.kind      = ROW_CHECKED;
        row.want.x    = CW'(ex);
        row.want.y    = CW'(ey);
        row.want.sat  = sat;
        row.want.zdiv = zdiv;
        return row;
    endfunction

    function automatic t_stim_row row_coef(input t_cfg_idx idx,
                                           input logic signed [KW-1:0] val);
        t_stim_row row;
        row = row_pt(0, 0);
        row.kind = ROW_COEF;
        row.idx  = idx;
        row.coef = val;
        return row;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input t_stim_row row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Offers one point after a random gap (none in burst mode) and holds it until it is taken.
    task automatic send_point(input logic signed [CW-1:0] px,
                              input logic signed [CW-1:0] py,
                              input logic checked, input t_mapped_pt want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_x_in      <= px;
        i_y_in      <= py;
        req_checked <= checked;
        req_want    <= want;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Stops sending and waits until every expected point has come back.
    task automatic settle_idle();
        i_valid <= 1'b0;
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic load_coef(input t_cfg_idx idx, input logic signed [KW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        coef_copy[idx] = val;
    endtask

    // Every accepted request queues its expected mapped point.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (req_checked) begin
                expected_pts.insert(expected_pts.size(), req_want);
            end else begin
                expected_pts.insert(expected_pts.size(), map_point(i_x_in, i_y_in));
            end
        end
    end

    // Result side: random stall spans and comparison against the oldest entry.
    always @(posedge i_clk) begin : result_check
        t_mapped_pt want;
        t_mapped_pt got;
        if (!i_rst_n) begin
            hold_cnt = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got.x    = o_x_out;
                got.y    = o_y_out;
                got.sat  = o_saturated;
                got.zdiv = o_zero_divisor;
                if (expected_pts.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("Unexpected result x=%0d y=%0d sat=%0b zdiv=%0b",
                                 $signed(got.x), $signed(got.y), got.sat, got.zdiv);
                    end
                end else begin
                    want = expected_pts.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("Result differs: expected x=%0d y=%0d sat=%0b zdiv=%0b,",
                                     $signed(want.x), $signed(want.y), want.sat, want.zdiv);
                            $display("                got      x=%0d y=%0d sat=%0b zdiv=%0b",
                                     $signed(got.x), $signed(got.y), got.sat, got.zdiv);
                        end
                    end
                end
                hold_cnt = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (hold_cnt > 0) begin
                hold_cnt--;
            end
        end
        i_stall <= (hold_cnt != 0);
    end

    // Ends the run when neither channel makes progress for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        t_coef_style  style;
        bit           busy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;

        // Reset leaves the identity homography loaded.
        coef_copy[CFG_COEF_XX] = ONE_Q;
        coef_copy[CFG_COEF_XY] = '0;
        coef_copy[CFG_COEF_XT] = '0;
        coef_copy[CFG_COEF_YX] = '0;
        coef_copy[CFG_COEF_YY] = ONE_Q;
        coef_copy[CFG_COEF_YT] = '0;
        coef_copy[CFG_COEF_WX] = '0;
        coef_copy[CFG_COEF_WY] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Identity mapping returns the point unchanged.
        add_row(row_chk(0, 0, 0, 0, 0, 0));
        add_row(row_chk(32767, 32767, 32767, 32767, 0, 0));
        add_row(row_chk(-32768, -32768, -32768, -32768, 0, 0));
        add_row(row_chk(-32768, 32767, -32768, 32767, 0, 0));
        add_row(row_chk(21845, -21846, 21845, -21846, 0, 0));
        // Doubling x clamps large coordinates at both ends.
        add_row(row_coef(CFG_COEF_XX, TWO_Q));
        add_row(row_chk(20000, 5, 32767, 5, 1, 0));
        add_row(row_chk(-20000, -3, -32768, -3, 1, 0));
        // With w = 1 - x, the point x = 1.0 has a zero divisor.
        add_row(row_coef(CFG_COEF_WX, -ONE_Q));
        add_row(row_chk(16, 100, 0, 0, 0, 1));
        add_row(row_pt(32, 7));
        add_row(row_pt(-16, 1));
        // Extreme coefficients on every register.
        add_row(row_coef(CFG_COEF_XX, COEF_MAX));
        add_row(row_coef(CFG_COEF_XY, COEF_MIN));
        add_row(row_coef(CFG_COEF_XT, COEF_MAX));
        add_row(row_coef(CFG_COEF_YX, COEF_MIN));
        add_row(row_coef(CFG_COEF_YY, COEF_MAX));
        add_row(row_coef(CFG_COEF_YT, COEF_MIN));
        add_row(row_coef(CFG_COEF_WX, COEF_MAX));
        add_row(row_coef(CFG_COEF_WY, COEF_MIN));
        add_row(row_chk(0, 0, 32767, -32768, 1, 0));
        add_row(row_pt(32767, -32768));
        add_row(row_pt(-32768, 32767));
        add_row(row_pt(1, 1));
        // Half scale exposes rounding of exact ties away from zero.
        add_row(row_coef(CFG_COEF_XX, HALF_Q));
        add_row(row_coef(CFG_COEF_XY, '0));
        add_row(row_coef(CFG_COEF_XT, '0));
        add_row(row_coef(CFG_COEF_YX, '0));
        add_row(row_coef(CFG_COEF_YY, HALF_Q));
        add_row(row_coef(CFG_COEF_YT, '0));
        add_row(row_coef(CFG_COEF_WX, '0));
        add_row(row_coef(CFG_COEF_WY, '0));
        add_row(row_chk(1, -1, 1, -1, 0, 0));
        add_row(row_chk(3, -3, 2, -2, 0, 0));
        add_row(row_pt(-32768, 32767));

        busy = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_COEF) begin
                if (busy) begin
                    settle_idle();
                end
                busy = 1'b0;
                load_coef(dir_rows[r].idx, dir_rows[r].coef);
            end else begin
                send_point(dir_rows[r].x, dir_rows[r].y,
                           dir_rows[r].kind == ROW_CHECKED, dir_rows[r].want);
                busy = 1'b1;
            end
        end

        // Random phases, each with a fresh coefficient set and idling mode.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            case (ph % 4)
                2: style = STYLE_WILD;
                3: style = STYLE_SINGULAR;
                default: style = STYLE_AFFINE;
            endcase
            hunt_shift = $urandom_range(0, 10);
            for (int i = 0; i < 8; i++) begin
                load_coef(t_cfg_idx'(i), pick_coef(style, t_cfg_idx'(i)));
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                px = rand_coord();
                py = rand_coord();
                if (style == STYLE_SINGULAR && $urandom_range(0, 9) < 3) begin
                    px = CW'(16 << hunt_shift);
                end
                send_point(px, py, 1'b0, '0);
            end
        end
        settle_idle();

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> homography_point_transform_core.f
+incdir+rtl
rtl/hpt_pkg.sv
rtl/hpt_mac.sv
rtl/hpt_prep.sv
rtl/hpt_div.sv
rtl/homography_point_transform_core.sv
tb/tb.sv
